FILE: src/tdd_pkg.sv
// Package for the timed digest denylist block: sizes, item types, FSM states.
// No dependencies; every other file of the block but tdd_ram imports it.
`default_nettype none
package tdd_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int DIGEST_BYTES = 32;
	localparam int DG_WORDS     = 4;
	localparam int SLOT_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int TIME_W       = 48;
	localparam int EXP_W        = 32;
	localparam int THR_W        = 7;
	localparam int DG_W         = 64;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	typedef struct packed {
		logic              action;
		logic [DG_W-1:0]   digest_word0;
		logic [DG_W-1:0]   digest_word1;
		logic [DG_W-1:0]   digest_word2;
		logic [DG_W-1:0]   digest_word3;
		logic              digest_present;
		logic [TIME_W-1:0] now_time;
		logic [EXP_W-1:0]  expires_after;
		logic              backend_up;
	} item_t;

	typedef struct packed {
		logic             healthy;
		logic             object_denied;
		logic             threshold_reached;
		logic [THR_W-1:0] entry_count;
		logic             add_refused;
	} result_t;

	// Control from the sequencer to the order list.
	typedef struct packed {
		logic              push;
		logic              rotate;
		logic              keep;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  len;
	} order_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RD,
		ST_EV,
		ST_DONE
	} state_t;

	// Significant bits of digest word w.
	function automatic logic [DG_W-1:0] word_mask(input int w);
		int nb;
		int lo;
		nb = DIGEST_BYTES;
		lo = w * 8;
		if (nb >= lo + 8) begin
			return '1;
		end else if (nb <= lo) begin
			return '0;
		end
		return (DG_W'(1) << ((nb - lo) * 8)) - DG_W'(1);
	endfunction

endpackage
`default_nettype wire

FILE: src/tdd_item_if.sv
// Input channel of the denylist block: valid/ready with one item payload.
// Depends on tdd_pkg.
`default_nettype none
interface tdd_item_if import tdd_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/tdd_result_if.sv
// Output channel of the denylist block: valid/ready with one result payload.
// Depends on tdd_pkg.
`default_nettype none
interface tdd_result_if import tdd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/tdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/tdd_order.sv
// Newest-first slot order list: push at the head, or rotate the head to the
// tail of the live part (keep) or out of the list (drop). Depends on tdd_pkg.
`default_nettype none
module tdd_order import tdd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire order_ctl_t        ctl,
	output logic      [SLOT_W-1:0] head
);
	logic [SLOT_W-1:0] order_q [TABLE_DEPTH];
	logic [SLOT_W-1:0] order_d [TABLE_DEPTH];

	assign head = order_q[0];

	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			order_d[k] = order_q[k];
			if (ctl.push) begin
				order_d[k] = (k == 0) ? ctl.slot : order_q[(k == 0) ? 0 : k - 1];
			end else if (ctl.rotate) begin
				if (ctl.keep && CNT_W'(k + 1) == ctl.len) begin
					order_d[k] = order_q[0];
				end else if (k < TABLE_DEPTH - 1) begin
					order_d[k] = order_q[(k < TABLE_DEPTH - 1) ? k + 1 : k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				order_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				order_q[k] <= order_d[k];
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/timed_digest_denylist_health_top.sv
// Top level of the timed digest denylist: sequencer, slot bookkeeping and the
// shared deadline/digest compare. Depends on tdd_pkg, tdd_item_if,
// tdd_result_if, tdd_ram and tdd_order.
//
// Usage:
//   item   - input channel (valid/ready). action 0 adds a digest with deadline
//            now_time + expires_after (saturating); action 1 runs a health check.
//   result - output channel (valid/ready), exactly one result per item.
//   cfg_we/cfg_wdata - write deny_threshold; write only while the block is idle.
// Sequence:
//   One item at a time; item.ready is high only while the sequencer is idle.
//   Add: take the item, scan the slot-free bits from slot 0 for a free slot,
//   write that slot, then present the result.
//   Check: bypass goes straight to the result; otherwise each entry in the
//   table gets a registered RAM read of the head slot, then compare and rotate,
//   one entry at a time through the single deadline/digest comparator.
// Reset clears the order list, marks all slots free, zeroes the count and the
// threshold. The digest and deadline RAMs are not cleared; only listed slots
// are ever read. A result that is not taken is held in the output register
// and the sequencer waits in its final state until the register frees up.
`default_nettype none
module timed_digest_denylist_health_top import tdd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [THR_W-1:0] cfg_wdata,
	tdd_item_if.sink              item,
	tdd_result_if.source          result
);
	state_t state_q, state_d;

	logic [THR_W-1:0]       thr_q;
	item_t                  item_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       steps_q;
	logic [SLOT_W-1:0]      scan_q;
	logic [TABLE_DEPTH-1:0] slot_free_q;
	logic                   refused_q;
	logic                   bypass_q;
	logic                   checking_q;
	logic                   match_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   accept;
	logic                   out_free;
	logic                   table_full;
	logic                   take_bypass;
	logic [SLOT_W-1:0]      head;
	order_ctl_t             order_ctl;
	logic                   ram_we;
	logic                   eval;
	logic                   load_out;

	logic [DG_W-1:0]        dg_rd [DG_WORDS];
	logic [DG_W-1:0]        dg_in [DG_WORDS];
	logic [TIME_W-1:0]      dl_rd;
	logic [TIME_W:0]        dl_sum;
	logic [TIME_W-1:0]      dl_new;
	logic                   expired;
	logic                   dg_eq;
	logic                   drop;
	logic                   hit;
	logic                   reached;
	result_t                out_d;

	assign accept      = item.valid && item.ready;
	assign out_free    = !out_valid_q || result.ready;
	assign table_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign take_bypass = (thr_q == '0) || (count_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.payload.action == ACT_ADD) begin
						state_d = table_full ? ST_DONE : ST_SCAN;
					end else begin
						state_d = take_bypass ? ST_DONE : ST_RD;
					end
				end
			end
			ST_SCAN: begin
				if (slot_free_q[scan_q]) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_RD:    state_d = ST_EV;
			ST_EV:    state_d = (steps_q == CNT_W'(1)) ? ST_DONE : ST_RD;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control decode.
	always_comb begin
		item.ready = 1'b0;
		ram_we     = 1'b0;
		eval       = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE:  item.ready = 1'b1;
			ST_WRITE: ram_we = 1'b1;
			ST_EV:    eval = 1'b1;
			ST_DONE:  load_out = out_free;
			default: begin
			end
		endcase
	end

	// Shared compare unit: deadline against now, masked digest equality.
	assign dg_in[0] = item_q.digest_word0;
	assign dg_in[1] = item_q.digest_word1;
	assign dg_in[2] = item_q.digest_word2;
	assign dg_in[3] = item_q.digest_word3;

	always_comb begin
		dg_eq = 1'b1;
		for (int w = 0; w < DG_WORDS; w++) begin
			if ((dg_rd[w] & word_mask(w)) != (dg_in[w] & word_mask(w))) begin
				dg_eq = 1'b0;
			end
		end
	end

	assign expired = dl_rd < item_q.now_time;
	assign drop    = eval && checking_q && expired;
	assign hit     = eval && checking_q && !expired && item_q.digest_present && dg_eq;

	// Saturating deadline for an add.
	assign dl_sum = {1'b0, item_q.now_time} + {{(TIME_W + 1 - EXP_W){1'b0}}, item_q.expires_after};
	assign dl_new = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	always_comb begin
		order_ctl.push   = ram_we;
		order_ctl.rotate = eval;
		order_ctl.keep   = !drop;
		order_ctl.slot   = scan_q;
		order_ctl.len    = count_q;
	end

	tdd_order u_order (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (order_ctl),
		.head   (head)
	);

	for (genvar w = 0; w < DG_WORDS; w++) begin : g_dg_ram
		tdd_ram #(.WIDTH(DG_W), .DEPTH(TABLE_DEPTH)) u_dg_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (scan_q),
			.wdata (dg_in[w] & word_mask(w)),
			.raddr (head),
			.rdata (dg_rd[w])
		);
	end

	tdd_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_dl_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scan_q),
		.wdata (dl_new),
		.raddr (head),
		.rdata (dl_rd)
	);

	// Result composed from the final count.
	assign reached = (CNT_W'(thr_q) <= count_q);

	always_comb begin
		out_d                   = '0;
		out_d.entry_count       = THR_W'(count_q);
		if (item_q.action == ACT_ADD) begin
			out_d.add_refused = refused_q;
		end else if (bypass_q) begin
			out_d.healthy = item_q.backend_up;
		end else begin
			out_d.object_denied     = match_q;
			out_d.threshold_reached = reached;
			out_d.healthy           = (match_q || reached) ? 1'b0 : item_q.backend_up;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// Hold the accepted item for the whole sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item.payload;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= '0;
			count_q     <= '0;
			steps_q     <= '0;
			scan_q      <= '0;
			slot_free_q <= '1;
			refused_q   <= 1'b0;
			bypass_q    <= 1'b0;
			checking_q  <= 1'b0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (accept) begin
				scan_q     <= '0;
				steps_q    <= count_q;
				refused_q  <= (item.payload.action == ACT_ADD) && table_full;
				bypass_q   <= take_bypass;
				checking_q <= 1'b1;
				match_q    <= 1'b0;
			end
			// Advance the free-slot scan until a free bit is found.
			if (state_q == ST_SCAN && !slot_free_q[scan_q]) begin
				scan_q <= scan_q + SLOT_W'(1);
			end
			if (ram_we) begin
				slot_free_q[scan_q] <= 1'b0;
				count_q             <= count_q + CNT_W'(1);
			end
			if (eval) begin
				steps_q <= steps_q - CNT_W'(1);
				if (drop) begin
					slot_free_q[head] <= 1'b1;
					count_q           <= count_q - CNT_W'(1);
				end
				// Stop checking after the first live match; rotate the rest as is.
				if (hit) begin
					match_q    <= 1'b1;
					checking_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_scan_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_q == '1) |-> slot_free_q[scan_q])
		else $error("free-slot scan ran off the end");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.add_refused)
		|-> (result.payload.entry_count == THR_W'(TABLE_DEPTH)))
		else $error("add refused with room in the table");
`endif

endmodule
`default_nettype wire

FILE: tb/tdd_tb_chk.sv
// Checker for the timed digest denylist: watches both channels, predicts
// each result from its own copy of the table, and counts mismatches. Uses tdd_pkg.
`timescale 1ns / 1ps
module tdd_tb_chk import tdd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [THR_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire item_t            in_item,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire result_t          out_res,
	output int                    fail_count,
	output int                    pending
);
	logic [SLOT_W-1:0] order_q [TABLE_DEPTH];
	logic              free_q [TABLE_DEPTH];
	logic [DG_W-1:0]   dig_q [TABLE_DEPTH][DG_WORDS];
	logic [TIME_W-1:0] dl_q [TABLE_DEPTH];
	int                count_q;
	logic [THR_W-1:0]  thresh_q;
	result_t           verdicts [$];

	assign pending = verdicts.size();

	function automatic logic dig_match(int s, item_t it);
		logic [DG_W-1:0] w [DG_WORDS];
		w[0] = it.digest_word0;
		w[1] = it.digest_word1;
		w[2] = it.digest_word2;
		w[3] = it.digest_word3;
		for (int k = 0; k < DG_WORDS; k++) begin
			if ((dig_q[s][k] & word_mask(k)) != (w[k] & word_mask(k))) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic result_t judge_item(item_t it);
		result_t r;
		int slot, pos, s;
		logic [TIME_W:0] dl;
		logic hit, reached;
		r = '0;
		if (it.action == ACT_ADD) begin
			slot = -1;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				if (slot < 0 && free_q[k]) slot = k;
			end
			if (count_q >= TABLE_DEPTH || slot < 0) begin
				r.add_refused = 1'b1;
			end else begin
				dl = {1'b0, it.now_time} + it.expires_after;
				if (dl[TIME_W]) dl = {1'b0, {TIME_W{1'b1}}};
				dig_q[slot][0] = it.digest_word0;
				dig_q[slot][1] = it.digest_word1;
				dig_q[slot][2] = it.digest_word2;
				dig_q[slot][3] = it.digest_word3;
				dl_q[slot] = dl[TIME_W-1:0];
				free_q[slot] = 1'b0;
				for (int k = count_q; k > 0; k--) order_q[k] = order_q[k-1];
				order_q[0] = SLOT_W'(slot);
				count_q++;
			end
		end else if (thresh_q == 0 || count_q == 0) begin
			r.healthy = it.backend_up;
		end else begin
			pos = 0;
			hit = 1'b0;
			while (pos < count_q && !hit) begin
				s = order_q[pos];
				if (dl_q[s] < it.now_time) begin
					free_q[s] = 1'b1;
					for (int k = pos; k + 1 < count_q; k++) order_q[k] = order_q[k+1];
					count_q--;
					order_q[count_q] = '0;
				end else if (it.digest_present && dig_match(s, it)) begin
					hit = 1'b1;
				end else begin
					pos++;
				end
			end
			reached = (int'(thresh_q) <= count_q);
			r.object_denied = hit;
			r.threshold_reached = reached;
			r.healthy = (hit || reached) ? 1'b0 : it.backend_up;
		end
		r.entry_count = THR_W'(count_q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				order_q[k] <= '0;
				free_q[k] <= 1'b1;
			end
			count_q <= 0;
			thresh_q <= '0;
			fail_count <= 0;
			verdicts.delete();
		end else begin
			if (cfg_we) thresh_q = cfg_wdata;
			if (out_valid && out_ready) begin
				if (verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %p", out_res);
				end else begin
					want = verdicts.pop_front();
					if (want !== out_res) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, out_res);
					end
				end
			end
			if (in_valid && in_ready) verdicts.push_back(judge_item(in_item));
		end
	end
endmodule

FILE: tb/tb_timed_digest_denylist_health_top.sv
// Testbench top for the timed digest denylist: clock, reset, stimulus, verdict.
// Depends on tdd_pkg, both channel interfaces, tdd_tb_chk and the block.
`timescale 1ns / 1ps
module tb_timed_digest_denylist_health_top;
	import tdd_pkg::*;

	localparam int WATCHDOG = 20000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               stall_pct;
	int               idle_cycles;
	logic [DG_W-1:0]  pool [8][DG_WORDS];
	logic [TIME_W-1:0] clock_ms;

	tdd_item_if   item ();
	tdd_result_if result ();

	timed_digest_denylist_health_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item.sink),
		.result   (result.source)
	);

	tdd_tb_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_item   (item.payload),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (result.payload),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Count cycles with no transfer on either channel; give up past the limit.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("tb_timed_digest_denylist_health_top: done, errors");
				$finish;
			end
		end
	end

	// Receiver: stall at random at the falling edge, never when stall_pct is zero.
	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hold one item on the channel until it transfers; drop valid in random gaps.
	task automatic send_item(item_t it);
		while ($urandom_range(99) < stall_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.payload <= it;
		item.valid   <= 1'b1;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Build an item; digests come mostly from a small pool so checks can hit.
	function automatic item_t make_item(logic act, int pick);
		item_t it;
		it.action = act;
		if (pick >= 0) begin
			it.digest_word0 = pool[pick][0];
			it.digest_word1 = pool[pick][1];
			it.digest_word2 = pool[pick][2];
			it.digest_word3 = pool[pick][3];
		end else begin
			it.digest_word0 = {$urandom, $urandom};
			it.digest_word1 = {$urandom, $urandom};
			it.digest_word2 = {$urandom, $urandom};
			it.digest_word3 = {$urandom, $urandom};
		end
		it.digest_present = $urandom_range(3) != 0;
		it.now_time = clock_ms;
		it.expires_after = $urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(400));
		it.backend_up = 1'($urandom_range(1));
		return it;
	endfunction

	// Drop valid, wait until every expected result is in, then let the block settle.
	task automatic drain();
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (140) @(negedge clk);
	endtask

	task automatic set_threshold(logic [THR_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t it;
		logic [THR_W-1:0] thr_set [6];
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		item.valid   = 1'b0;
		item.payload = '0;
		result.ready = 1'b0;
		stall_pct    = 0;
		idle_cycles  = 0;
		clock_ms     = 48'd1000;
		for (int p = 0; p < 8; p++) begin
			for (int k = 0; k < DG_WORDS; k++) pool[p][k] = {$urandom, $urandom};
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: bypass with zero threshold, then adds and checks at the edges.
		it = make_item(ACT_CHECK, 0);
		it.backend_up = 1'b1;
		send_item(it);
		it = make_item(ACT_ADD, -1);
		it.digest_word0 = '1; it.digest_word1 = '1; it.digest_word2 = '1; it.digest_word3 = '1;
		send_item(it);
		set_threshold(7'd1);
		// Empty-table bypass after the expiry sweep takes the only entry.
		it = make_item(ACT_CHECK, 0);
		it.now_time = '1;
		send_item(it);
		it = make_item(ACT_CHECK, 0);
		send_item(it);
		// Saturating deadline and an entry that ends exactly at now.
		it = make_item(ACT_ADD, 1);
		it.now_time = '1 - 48'd5;
		it.expires_after = '1;
		send_item(it);
		it = make_item(ACT_ADD, 2);
		it.now_time = 48'd2000;
		it.expires_after = '0;
		send_item(it);
		it = make_item(ACT_CHECK, 2);
		it.now_time = 48'd2000;
		it.digest_present = 1'b1;
		send_item(it);
		it = make_item(ACT_CHECK, 1);
		it.now_time = 48'd2001;
		it.digest_present = 1'b0;
		send_item(it);
		// Fill the table past full so the last adds are refused.
		set_threshold(7'd127);
		for (int n = 0; n < 66; n++) begin
			it = make_item(ACT_ADD, n % 8);
			it.now_time = 48'd3000;
			it.expires_after = 32'(10 + n);
			send_item(it);
		end
		it = make_item(ACT_CHECK, 3);
		it.now_time = 48'd3040;
		send_item(it);
		it = make_item(ACT_CHECK, 4);
		it.now_time = '1;
		send_item(it);

		// Random phases over several thresholds, extremes included.
		thr_set = '{7'd0, 7'd64, 7'd3, 7'd127, 7'd12, 7'd1};
		clock_ms = 48'd5000;
		for (int ph = 0; ph < 6; ph++) begin
			set_threshold(thr_set[ph]);
			// One phase runs with no idling on either side.
			stall_pct = (ph == 2) ? 0 : 25;
			for (int n = 0; n < 120; n++) begin
				clock_ms = clock_ms + TIME_W'($urandom_range(20));
				it = make_item($urandom_range(99) < 55 ? ACT_ADD : ACT_CHECK,
					$urandom_range(9) < 8 ? int'($urandom_range(7)) : -1);
				if ($urandom_range(49) == 0) it.now_time = TIME_W'({$urandom, $urandom});
				send_item(it);
			end
		end
		stall_pct = 0;

		drain();
		if (fail_count == 0) begin
			$display("tb_timed_digest_denylist_health_top: done, clean");
		end else begin
			$display("tb_timed_digest_denylist_health_top: done, errors");
		end
		$finish;
	end
endmodule

FILE: timed_digest_denylist_health_top.f
src/tdd_pkg.sv
src/tdd_item_if.sv
src/tdd_result_if.sv
src/tdd_ram.sv
src/tdd_order.sv
src/timed_digest_denylist_health_top.sv
tb/tdd_tb_chk.sv
tb/tb_timed_digest_denylist_health_top.sv
